>>> rtl/core/kpv1d_pkg.sv
// Types, codes, micro-program and helper functions for the 1-D position/velocity filter.
package kpv1d_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int DivBits  = WordBits + FracBits;
  localparam int StepBits = 5;

  typedef enum logic [1:0] {
    CMD_PREDICT = 2'd0,
    CMD_CORRECT = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SKIP = 2'd1,
    STAT_SAT  = 2'd2,
    STAT_RSVD = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_PROCESS_NOISE     = 1'b0,
    CFG_OBSERVATION_NOISE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    UOP_MUL,
    UOP_ADD,
    UOP_SUB,
    UOP_DIV,
    UOP_SKIPZ,
    UOP_END
  } uop_e;

  typedef enum logic [4:0] {
    RG_ZERO, RG_DT, RG_DT2, RG_DT3, RG_DT4, RG_HALF, RG_U, RG_Z, RG_VIN,
    RG_SIG, RG_R, RG_POS, RG_VEL, RG_P00, RG_P01, RG_P11, RG_T0, RG_T1,
    RG_ACC, RG_S, RG_E, RG_K0, RG_K1
  } reg_e;

  typedef struct packed {
    uop_e kind;
    reg_e a;
    reg_e b;
    reg_e dst;
  } uop_t;

  typedef struct packed {
    logic [WordBits-1:0] val;
    logic                sat;
  } res_t;

  function automatic uop_t mk(uop_e k, reg_e a, reg_e b, reg_e d);
    uop_t u;
    u.kind = k;
    u.a    = a;
    u.b    = b;
    u.dst  = d;
    return u;
  endfunction

  function automatic uop_t prog(cmd_e cmd, logic [StepBits-1:0] step);
    uop_t u;
    u = mk(UOP_END, RG_ZERO, RG_ZERO, RG_ZERO);
    case (cmd)
      CMD_PREDICT: begin
        case (step)
          5'd0:  u = mk(UOP_MUL, RG_DT,   RG_DT,   RG_DT2);
          5'd1:  u = mk(UOP_MUL, RG_DT2,  RG_DT,   RG_DT3);
          5'd2:  u = mk(UOP_MUL, RG_DT3,  RG_DT,   RG_DT4);
          5'd3:  u = mk(UOP_MUL, RG_DT,   RG_VEL,  RG_ACC);
          5'd4:  u = mk(UOP_ADD, RG_POS,  RG_ACC,  RG_POS);
          5'd5:  u = mk(UOP_MUL, RG_HALF, RG_U,    RG_ACC);
          5'd6:  u = mk(UOP_ADD, RG_POS,  RG_ACC,  RG_POS);
          5'd7:  u = mk(UOP_MUL, RG_DT,   RG_U,    RG_ACC);
          5'd8:  u = mk(UOP_ADD, RG_VEL,  RG_ACC,  RG_VEL);
          5'd9:  u = mk(UOP_MUL, RG_DT,   RG_P01,  RG_ACC);
          5'd10: u = mk(UOP_ADD, RG_P00,  RG_ACC,  RG_T0);
          5'd11: u = mk(UOP_MUL, RG_DT,   RG_P11,  RG_ACC);
          5'd12: u = mk(UOP_ADD, RG_P01,  RG_ACC,  RG_T1);
          5'd13: u = mk(UOP_MUL, RG_DT,   RG_T1,   RG_ACC);
          5'd14: u = mk(UOP_ADD, RG_T0,   RG_ACC,  RG_T0);
          5'd15: u = mk(UOP_MUL, RG_SIG,  RG_DT4,  RG_ACC);
          5'd16: u = mk(UOP_ADD, RG_T0,   RG_ACC,  RG_P00);
          5'd17: u = mk(UOP_MUL, RG_SIG,  RG_DT3,  RG_ACC);
          5'd18: u = mk(UOP_ADD, RG_T1,   RG_ACC,  RG_P01);
          5'd19: u = mk(UOP_MUL, RG_SIG,  RG_DT2,  RG_ACC);
          5'd20: u = mk(UOP_ADD, RG_P11,  RG_ACC,  RG_P11);
          default: u = mk(UOP_END, RG_ZERO, RG_ZERO, RG_ZERO);
        endcase
      end
      CMD_CORRECT: begin
        case (step)
          5'd0:  u = mk(UOP_ADD,   RG_P00, RG_R,    RG_S);
          5'd1:  u = mk(UOP_SKIPZ, RG_S,   RG_ZERO, RG_ZERO);
          5'd2:  u = mk(UOP_SUB,   RG_Z,   RG_POS,  RG_E);
          5'd3:  u = mk(UOP_DIV,   RG_P00, RG_S,    RG_K0);
          5'd4:  u = mk(UOP_DIV,   RG_P01, RG_S,    RG_K1);
          5'd5:  u = mk(UOP_MUL,   RG_K0,  RG_P00,  RG_ACC);
          5'd6:  u = mk(UOP_SUB,   RG_P00, RG_ACC,  RG_T0);
          5'd7:  u = mk(UOP_MUL,   RG_K0,  RG_P01,  RG_ACC);
          5'd8:  u = mk(UOP_SUB,   RG_P01, RG_ACC,  RG_T1);
          5'd9:  u = mk(UOP_MUL,   RG_K1,  RG_P01,  RG_ACC);
          5'd10: u = mk(UOP_SUB,   RG_P11, RG_ACC,  RG_P11);
          5'd11: u = mk(UOP_MUL,   RG_K0,  RG_E,    RG_ACC);
          5'd12: u = mk(UOP_ADD,   RG_POS, RG_ACC,  RG_POS);
          5'd13: u = mk(UOP_MUL,   RG_K1,  RG_E,    RG_ACC);
          5'd14: u = mk(UOP_ADD,   RG_VEL, RG_ACC,  RG_VEL);
          5'd15: u = mk(UOP_ADD,   RG_T0,  RG_ZERO, RG_P00);
          5'd16: u = mk(UOP_ADD,   RG_T1,  RG_ZERO, RG_P01);
          default: u = mk(UOP_END, RG_ZERO, RG_ZERO, RG_ZERO);
        endcase
      end
      CMD_LOAD: begin
        case (step)
          5'd0:  u = mk(UOP_ADD, RG_Z,   RG_ZERO, RG_POS);
          5'd1:  u = mk(UOP_ADD, RG_VIN, RG_ZERO, RG_VEL);
          default: u = mk(UOP_END, RG_ZERO, RG_ZERO, RG_ZERO);
        endcase
      end
      default: u = mk(UOP_END, RG_ZERO, RG_ZERO, RG_ZERO);
    endcase
    return u;
  endfunction

  // Sign-magnitude to saturated word.
  function automatic res_t finish(logic neg, logic [DivBits-1:0] m);
    res_t r;
    logic [DivBits-1:0] lim;
    lim = neg ? DivBits'(64'h8000_0000) : DivBits'(64'h7FFF_FFFF);
    if (m > lim) begin
      r.sat = 1'b1;
      r.val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r.sat = 1'b0;
      r.val = neg ? (32'd0 - m[WordBits-1:0]) : m[WordBits-1:0];
    end
    return r;
  endfunction

  function automatic res_t clamp34(logic signed [WordBits+1:0] x);
    res_t r;
    if (x > 34'sh0_7FFF_FFFF) begin
      r.sat = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else if (x < -34'sh0_8000_0000) begin
      r.sat = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = x[WordBits-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/kalman_position_velocity_1d.sv
// Two-state Kalman filter with one shared multiply/add unit and a bit-serial divider.
// Correct runs two divisions in the bit-serial divider; a correct with zero S is skipped.
// Throughput: one item at a time; s_axis_tready is low from accept until the
// result has moved into the output register.
// Reset: clears the estimate and covariance, sets both noise registers to 1.0.
module kalman_position_velocity_1d
  import kpv1d_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // time_step[15:0], accel_input[47:16], position_value[79:48], velocity_value[111:80]
  input  logic [111:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // position_estimate[31:0], velocity_estimate[63:32]
  output logic [63:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);

  state_e state_q, state_d;
  logic [StepBits-1:0] step_q;
  cmd_e  cmd_q;
  logic [15:0] dt_q;
  logic [31:0] u_q, z_q, vin_q;
  logic [31:0] sig_q, r_q;
  logic [31:0] pos_q, vel_q, p00_q, p01_q, p11_q;
  logic [31:0] t0_q, t1_q, acc_q, s_q, e_q, k0_q, k1_q, dt2_q, dt3_q, dt4_q;
  logic sat_q, skip_q;
  logic [31:0] div_rem_q, div_den_q;
  logic [DivBits-1:0] div_sh_q;
  logic [5:0] div_cnt_q;
  logic div_neg_q;
  logic out_valid_q;
  logic [63:0] out_data_q;
  status_e out_stat_q;

  uop_t uop;
  logic signed [32:0] opa, opb;
  logic [31:0] mag_a, mag_b;
  logic [63:0] prod;
  res_t mul_res, add_res, div_res, wb_res;
  logic signed [33:0] sum;
  logic [32:0] rem2;
  logic ge;
  logic [31:0] rem_n;
  logic [DivBits-1:0] sh_n;
  logic wb_en, div_last, accept, out_load, s_zero;

  function automatic logic signed [32:0] opnd(reg_e r);
    logic signed [32:0] v;
    case (r)
      RG_DT:   v = {17'd0, dt_q};
      RG_DT2:  v = {dt2_q[31], dt2_q};
      RG_DT3:  v = {dt3_q[31], dt3_q};
      RG_DT4:  v = {dt4_q[31], dt4_q};
      RG_HALF: v = {dt2_q[31], dt2_q[31], dt2_q[31:1]};
      RG_U:    v = {u_q[31], u_q};
      RG_Z:    v = {z_q[31], z_q};
      RG_VIN:  v = {vin_q[31], vin_q};
      RG_SIG:  v = {1'b0, sig_q};
      RG_R:    v = {1'b0, r_q};
      RG_POS:  v = {pos_q[31], pos_q};
      RG_VEL:  v = {vel_q[31], vel_q};
      RG_P00:  v = {p00_q[31], p00_q};
      RG_P01:  v = {p01_q[31], p01_q};
      RG_P11:  v = {p11_q[31], p11_q};
      RG_T0:   v = {t0_q[31], t0_q};
      RG_T1:   v = {t1_q[31], t1_q};
      RG_ACC:  v = {acc_q[31], acc_q};
      RG_S:    v = {s_q[31], s_q};
      RG_E:    v = {e_q[31], e_q};
      RG_K0:   v = {k0_q[31], k0_q};
      RG_K1:   v = {k1_q[31], k1_q};
      default: v = '0;
    endcase
    return v;
  endfunction

  assign uop   = prog(cmd_q, step_q);
  assign opa   = opnd(uop.a);
  assign opb   = opnd(uop.b);
  assign mag_a = opa[32] ? 32'(-opa) : opa[31:0];
  assign mag_b = opb[32] ? 32'(-opb) : opb[31:0];
  assign prod  = 64'(mag_a) * 64'(mag_b);
  assign mul_res = finish(opa[32] ^ opb[32], prod[63:FracBits]);
  assign sum   = (uop.kind == UOP_SUB) ? (34'(opa) - 34'(opb)) : (34'(opa) + 34'(opb));
  assign add_res = clamp34(sum);
  assign s_zero = (s_q == '0);

  assign rem2   = {div_rem_q, div_sh_q[DivBits-1]};
  assign ge     = rem2 >= {1'b0, div_den_q};
  assign rem_n  = ge ? 32'(rem2 - {1'b0, div_den_q}) : rem2[31:0];
  assign sh_n   = {div_sh_q[DivBits-2:0], ge};
  assign div_res  = finish(div_neg_q, sh_n);
  assign div_last = (state_q == ST_DIV) && (div_cnt_q == 6'd1);

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RUN;
      ST_RUN: begin
        unique case (uop.kind)
          UOP_DIV:   state_d = ST_DIV;
          UOP_END:   state_d = ST_OUT;
          UOP_SKIPZ: if (s_zero) state_d = ST_OUT;
          default:   state_d = ST_RUN;
        endcase
      end
      ST_DIV:  if (div_last) state_d = ST_RUN;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    cfg_ready_o   = 1'b1;
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = out_data_q;
    m_axis_tuser  = out_stat_q;
    wb_en  = 1'b0;
    wb_res = mul_res;
    if (div_last) begin
      wb_en  = 1'b1;
      wb_res = div_res;
    end else if (state_q == ST_RUN) begin
      case (uop.kind)
        UOP_MUL: begin
          wb_en  = 1'b1;
          wb_res = mul_res;
        end
        UOP_ADD, UOP_SUB: begin
          wb_en  = 1'b1;
          wb_res = add_res;
        end
        default: wb_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      sat_q       <= 1'b0;
      skip_q      <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      sig_q       <= 32'h0001_0000;
      r_q         <= 32'h0001_0000;
      pos_q       <= '0;
      vel_q       <= '0;
      p00_q       <= '0;
      p01_q       <= '0;
      p11_q       <= '0;
      cmd_q       <= CMD_NONE;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_PROCESS_NOISE:     sig_q <= cfg_data_i;
          CFG_OBSERVATION_NOISE: r_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        cmd_q  <= cmd_e'(s_axis_tuser);
        step_q <= '0;
        sat_q  <= 1'b0;
        skip_q <= 1'b0;
      end
      if (state_q == ST_RUN) begin
        if (uop.kind == UOP_DIV) begin
          div_cnt_q <= 6'(DivBits);
        end else if (uop.kind == UOP_SKIPZ && s_zero) begin
          skip_q <= 1'b1;
        end
        if (uop.kind != UOP_DIV && uop.kind != UOP_END) step_q <= step_q + 1'b1;
      end
      if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q - 1'b1;
        if (div_last) step_q <= step_q + 1'b1;
      end
      if (wb_en) begin
        sat_q <= sat_q | wb_res.sat;
        case (uop.dst)
          RG_POS: pos_q <= wb_res.val;
          RG_VEL: vel_q <= wb_res.val;
          RG_P00: p00_q <= wb_res.val;
          RG_P01: p01_q <= wb_res.val;
          RG_P11: p11_q <= wb_res.val;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q  <= s_axis_tdata[15:0];
      u_q   <= s_axis_tdata[47:16];
      z_q   <= s_axis_tdata[79:48];
      vin_q <= s_axis_tdata[111:80];
    end
    if (wb_en) begin
      case (uop.dst)
        RG_T0:  t0_q  <= wb_res.val;
        RG_T1:  t1_q  <= wb_res.val;
        RG_ACC: acc_q <= wb_res.val;
        RG_S:   s_q   <= wb_res.val;
        RG_E:   e_q   <= wb_res.val;
        RG_K0:  k0_q  <= wb_res.val;
        RG_K1:  k1_q  <= wb_res.val;
        RG_DT2: dt2_q <= wb_res.val;
        RG_DT3: dt3_q <= wb_res.val;
        RG_DT4: dt4_q <= wb_res.val;
        default: ;
      endcase
    end
    if (state_q == ST_RUN && uop.kind == UOP_DIV) begin
      div_rem_q <= '0;
      div_den_q <= mag_b;
      div_neg_q <= opa[32] ^ opb[32];
      div_sh_q  <= {mag_a, {FracBits{1'b0}}};
    end else if (state_q == ST_DIV) begin
      div_rem_q <= rem_n;
      div_sh_q  <= sh_n;
    end
    if (out_load) begin
      out_data_q <= {vel_q, pos_q};
      out_stat_q <= sat_q ? STAT_SAT : (skip_q ? STAT_SKIP : STAT_OK);
    end
  end

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_RUN) else $error("accept did not start the sequencer");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_cnt_q != 6'd0) else $error("divider count ran out");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid && state_q == ST_IDLE) else $error("result not presented");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != STAT_RSVD) else $error("reserved status code");
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skip_q) |-> s_zero && cmd_q == CMD_CORRECT) else $error("skip without zero S");

endmodule
